[hdl/nvs_pkg.sv]
// ----------------------------------------------------------------------------
// nvs_pkg: shared types and constants of the nearest-vertex search block
//   Field widths, register reset value, action codes and the command and
//   status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package nvs_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS_DEF   = 16;

    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd12;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic start;     // latch query point
        logic load;      // write table entry from input beat
        logic rd_en;     // read table entry for scoring
        logic rd_first;  // entry read is the first of the scan
        logic rd_last;   // entry read is the last of the scan
        logic publish;   // move best result into output register
    } nvs_cmd_t;

    typedef struct packed {
        logic scan_done; // last entry has been compared
        logic out_free;  // output register can take a result
    } nvs_status_t;

endpackage

[hdl/nvs_ram.sv]
// ----------------------------------------------------------------------------
// nvs_ram: generic simple dual-port RAM
//   One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nvs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/nvs_ctrl.sv]
// ----------------------------------------------------------------------------
// nvs_ctrl: nearest-vertex search controller
//   Holds the vertex count register, accepts input beats and sequences the
//   table scan of a query.
// ----------------------------------------------------------------------------
module nvs_ctrl #(
    parameter int MAX_VERTICES = nvs_pkg::MAX_VERTICES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [nvs_pkg::COUNT_W-1:0]     cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    output nvs_pkg::nvs_cmd_t               cmd,
    output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    input  nvs_pkg::nvs_status_t            status
);
    import nvs_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      last_reg, last_next;
    logic [COUNT_W-1:0] count_reg;
    logic [31:0]        count_eff;
    logic [31:0]        last_wide;
    logic               accept;

    // clamp count: zero scans one entry, oversize saturates to table depth
    always_comb begin
        count_eff = 32'(count_reg);
        if (count_eff == 32'd0) begin
            count_eff = 32'd1;
        end
        if (count_eff > 32'(MAX_VERTICES)) begin
            count_eff = 32'(MAX_VERTICES);
        end
        last_wide = count_eff - 32'd1;
    end

    assign accept  = s_valid && s_ready;
    assign rd_addr = addr_reg;

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        last_next  = last_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (s_action == ACT_QUERY) begin
                        cmd.start  = 1'b1;
                        addr_next  = '0;
                        last_next  = last_wide[AW-1:0];
                        state_next = ST_SCAN;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (addr_reg == '0);
                cmd.rd_last  = (addr_reg == last_reg);
                addr_next    = addr_reg + 1'b1;
                if (addr_reg == last_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.publish = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= COUNT_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        last_reg <= last_next;
    end

endmodule

[hdl/nvs_datapath.sv]
// ----------------------------------------------------------------------------
// nvs_datapath: vertex table, dot-product pipeline and best tracker
//   Read, multiply, sum and compare stages, one table entry per cycle,
//   followed by the output register.
// ----------------------------------------------------------------------------
module nvs_datapath #(
    parameter int MAX_VERTICES = nvs_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = nvs_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  nvs_pkg::nvs_cmd_t               cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    output nvs_pkg::nvs_status_t            status,
    input  logic [nvs_pkg::INDEX_W-1:0]     s_vertex_index,
    input  logic signed [COORD_BITS-1:0]    s_coord_x,
    input  logic signed [COORD_BITS-1:0]    s_coord_y,
    input  logic signed [COORD_BITS-1:0]    s_coord_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nvs_pkg::INDEX_W-1:0]     m_nearest_index,
    output logic signed [2*COORD_BITS:0]    m_best_score
);
    import nvs_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CB   = COORD_BITS;
    localparam int PW   = 2 * CB;
    localparam int SW   = 2 * CB + 1;
    localparam int SUMW = 2 * CB + 2;

    // table write from a load beat; drop indexes beyond the table
    logic [31:0]     widx;
    logic            wr_en;
    logic [3*CB-1:0] rd_data;

    assign widx  = 32'(s_vertex_index);
    assign wr_en = cmd.load && (widx < 32'(MAX_VERTICES));

    nvs_ram #(
        .WIDTH (3 * CB),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (widx[AW-1:0]),
        .wr_data ({s_coord_z, s_coord_y, s_coord_x}),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic signed [CB-1:0]   px_reg, py_reg, pz_reg;
    logic signed [CB-1:0]   vx, vy, vz;

    logic                   s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [AW-1:0]          s1_idx_reg;
    logic                   s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [AW-1:0]          s2_idx_reg;
    logic signed [PW-1:0]   prod_x_reg, prod_y_reg, prod_z_reg;
    logic                   s3_valid_reg, s3_first_reg, s3_last_reg;
    logic [AW-1:0]          s3_idx_reg;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic signed [SUMW-1:0] best_reg;
    logic [AW-1:0]          best_idx_reg;
    logic                   done_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]     m_index_reg;
    logic signed [SW-1:0]   m_score_reg;
    logic [31:0]            best_idx_wide;
    logic                   take;

    assign vx = rd_data[CB-1:0];
    assign vy = rd_data[2*CB-1:CB];
    assign vz = rd_data[3*CB-1:2*CB];

    assign sum_next = SUMW'(prod_x_reg) + SUMW'(prod_y_reg) + SUMW'(prod_z_reg);
    // strict greater keeps the lowest index on ties
    assign take = s3_valid_reg && (s3_first_reg || (sum_reg > best_reg));

    assign best_idx_wide = 32'(best_idx_reg);
    assign m_valid_next  = cmd.publish ? 1'b1 : (m_valid_reg && !m_ready);

    assign status.scan_done = done_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.rd_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg && s3_last_reg;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            px_reg <= s_coord_x;
            py_reg <= s_coord_y;
            pz_reg <= s_coord_z;
        end
        s1_first_reg <= cmd.rd_first;
        s1_last_reg  <= cmd.rd_last;
        s1_idx_reg   <= rd_addr;

        prod_x_reg   <= PW'(vx) * PW'(px_reg);
        prod_y_reg   <= PW'(vy) * PW'(py_reg);
        prod_z_reg   <= PW'(vz) * PW'(pz_reg);
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_idx_reg   <= s1_idx_reg;

        sum_reg      <= sum_next;
        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
        s3_idx_reg   <= s2_idx_reg;

        if (take) begin
            best_reg     <= sum_reg;
            best_idx_reg <= s3_idx_reg;
        end
        if (cmd.publish) begin
            m_index_reg <= best_idx_wide[INDEX_W-1:0];
            m_score_reg <= best_reg[SW-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_nearest_index = m_index_reg;
    assign m_best_score    = m_score_reg;

endmodule

[hdl/nearest_vertex_search.sv]
// ----------------------------------------------------------------------------
// nearest_vertex_search: nearest mesh vertex by largest dot product
//   Vertex direction table with a linear max-dot-product query scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one beat per item. s_action = load writes the
//   coordinates into table entry s_vertex_index and gives no
//   result; a load beyond the table depth is dropped. s_action = query takes
//   the coordinates as the point and scans entries 0 .. vertex_count-1.
//   Result channel (m_*): one beat per query with the winning index (lowest
//   on ties) and its full-precision Q3.30 dot product.
//   cfg_wr_en/cfg_wr_data write vertex_count (reset 12); zero scans one
//   entry, values above MAX_VERTICES scan the whole table. Write it only
//   while the block is idle.
// Timing:
//   Loads are accepted back to back while idle. A query reads one table
//   entry per cycle through the single read port of the table RAM and one
//   dot-product unit, so it occupies the block until its result is
//   registered; s_ready stays low meanwhile.
// Reset and stall:
//   aresetn (synchronous) clears the controller and valids and reloads
//   vertex_count; table contents are undefined until loaded. While the
//   result waits on m_ready, loads and a next query are still accepted; a
//   finished query holds until the output register frees up.
// ----------------------------------------------------------------------------
module nearest_vertex_search #(
    parameter int MAX_VERTICES = nvs_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = nvs_pkg::COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [nvs_pkg::COUNT_W-1:0] cfg_wr_data,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [nvs_pkg::INDEX_W-1:0] s_vertex_index,
    input  logic signed [COORD_BITS-1:0] s_coord_x,
    input  logic signed [COORD_BITS-1:0] s_coord_y,
    input  logic signed [COORD_BITS-1:0] s_coord_z,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [nvs_pkg::INDEX_W-1:0] m_nearest_index,
    output logic signed [2*COORD_BITS:0] m_best_score
);
    import nvs_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    nvs_cmd_t      cmd;
    nvs_status_t   status;
    logic [AW-1:0] rd_addr;

    // sequence beats and the scan
    nvs_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .status      (status)
    );

    // table, scoring pipeline and output register
    nvs_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .status          (status),
        .s_vertex_index  (s_vertex_index),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .s_coord_z       (s_coord_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nearest_index (m_nearest_index),
        .m_best_score    (m_best_score)
    );

endmodule

[hdl/nvs_checker.sv]
// ----------------------------------------------------------------------------
// nvs_checker: port-level checks of the nearest-vertex search block
//   Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module nvs_checker #(
    parameter int COORD_BITS = nvs_pkg::COORD_BITS_DEF
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_action,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [nvs_pkg::INDEX_W-1:0] m_nearest_index,
    input logic signed [2*COORD_BITS:0] m_best_score
);
    import nvs_pkg::*;

    // reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("block not idle after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_nearest_index) && $stable(m_best_score)))
        else $error("stalled result changed");

    // a query holds off the input right after it is accepted
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACT_QUERY)) |=> !s_ready)
        else $error("input accepted right after a query");

    // a load never raises a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACT_LOAD) && !m_valid) |=> !m_valid)
        else $error("result appeared after a load");

    // a result is published only while the input side is held off
    a_publish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised while input was open");

endmodule

bind nearest_vertex_search nvs_checker #(
    .COORD_BITS (COORD_BITS)
) u_nvs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_action        (s_action),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_nearest_index (m_nearest_index),
    .m_best_score    (m_best_score)
);
